// ===== src/string_escape_decoder_macros.svh =====
// ----------------------------------------------------------------------------
// String escape decoder assertion macros
// Shorthand for clocked implication checks used by the port checker.
// ----------------------------------------------------------------------------
`ifndef STRING_ESCAPE_DECODER_MACROS_SVH
`define STRING_ESCAPE_DECODER_MACROS_SVH

// same-cycle implication, quiet during reset
`define SED_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet during reset
`define SED_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/sed_pkg.sv =====
// ----------------------------------------------------------------------------
// sed_pkg
// Beat types, queue entry type and status codes of the string escape decoder.
// ----------------------------------------------------------------------------
package sed_pkg;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_BAD_HEX = 3'd1;
  localparam logic [2:0] ST_BAD_DEC = 3'd2;
  localparam logic [2:0] ST_BAD_UNI = 3'd3;
  localparam logic [2:0] ST_BAD_CP  = 3'd4;
  localparam logic [2:0] ST_BAD_OCT = 3'd5;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_end;
    logic [2:0] status;
  } out_t;

  // one input byte's worth of output: a number flush, a literal byte and
  // the string terminator, always in that order
  typedef struct packed {
    logic        fl_en;
    logic        fl_uni;
    logic [20:0] fl_val;
    logic        lit_en;
    logic [7:0]  lit_byte;
    logic        term_en;
    logic [2:0]  status;
  } job_t;

endpackage

// ===== src/sed_fifo.sv =====
// ----------------------------------------------------------------------------
// sed_fifo
// Small register queue of decode jobs between front and back.
// ----------------------------------------------------------------------------
module sed_fifo #(
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  sed_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output sed_pkg::job_t head_job
);
  import sed_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head_job   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== src/sed_front.sv =====
// ----------------------------------------------------------------------------
// sed_front
// Escape parser: takes one raw byte a cycle unless the queue is full, tracks
// escapes and digit runs, and queues a job describing the beats it produces.
// ----------------------------------------------------------------------------
module sed_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  sed_pkg::in_t  in_data,
  input  logic          q_full,
  output logic          push,
  output sed_pkg::job_t job
);
  import sed_pkg::*;

  typedef enum logic [2:0] {
    M_NORMAL, M_ESCAPE, M_FIRST, M_DIGITS, M_SKIP
  } mode_t;

  typedef enum logic [1:0] {K_HEX, K_DEC, K_UNI, K_OCT} kind_t;

  localparam logic [7:0] CH_BSL  = 8'h5C;
  localparam logic [7:0] CH_0    = "0";
  localparam logic [7:0] CH_7    = "7";
  localparam logic [7:0] CH_9    = "9";
  localparam logic [7:0] CH_LA   = "a";
  localparam logic [7:0] CH_LB   = "b";
  localparam logic [7:0] CH_LF   = "f";
  localparam logic [7:0] CH_LN   = "n";
  localparam logic [7:0] CH_LR   = "r";
  localparam logic [7:0] CH_LT   = "t";
  localparam logic [7:0] CH_LV   = "v";
  localparam logic [7:0] CH_LX   = "x";
  localparam logic [7:0] CH_UX   = "X";
  localparam logic [7:0] CH_LD   = "d";
  localparam logic [7:0] CH_UD   = "D";
  localparam logic [7:0] CH_LU   = "u";
  localparam logic [7:0] CH_UU   = "U";
  localparam logic [7:0] CH_LO   = "o";
  localparam logic [7:0] CH_UO   = "O";
  localparam logic [7:0] CH_UA   = "A";
  localparam logic [7:0] CH_UF   = "F";
  localparam logic [7:0] CTL_BEL = 8'h07;
  localparam logic [7:0] CTL_BS  = 8'h08;
  localparam logic [7:0] CTL_FF  = 8'h0C;
  localparam logic [7:0] CTL_LF  = 8'h0A;
  localparam logic [7:0] CTL_CR  = 8'h0D;
  localparam logic [7:0] CTL_HT  = 8'h09;
  localparam logic [7:0] CTL_VT  = 8'h0B;

  mode_t       mode, mode_next;
  kind_t       kind, kind_next;
  logic [3:0]  cnt, cnt_next;
  logic [31:0] acc, acc_next;
  logic [2:0]  err, err_next;

  logic        accept;
  logic [7:0]  b;
  logic        last;
  logic [3:0]  raw_val;
  logic        raw_ok;
  logic        dig_ok;
  logic [4:0]  radix;
  logic [3:0]  max_cnt;
  logic [2:0]  kind_err;
  logic [31:0] acc_mul;
  logic [3:0]  cnt_inc;
  logic        fl_req;
  logic        fl_bad;
  logic [31:0] fl_val;
  logic        lit_en;
  logic [7:0]  lit_byte;

  function automatic logic bad_cp(kind_t k, logic [31:0] v);
    return (k == K_UNI) &&
           ((v > 32'h0010_FFFF) || ((v >= 32'h0000_D800) && (v <= 32'h0000_DFFF)));
  endfunction

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign b        = in_data.in_byte;
  assign last     = in_data.in_last;

  // digit value in any radix, then checked against the current one
  always_comb begin
    raw_ok  = 1'b1;
    raw_val = 4'd0;
    if (b >= CH_0 && b <= CH_9) begin
      raw_val = 4'(b - CH_0);
    end else if (b >= CH_LA && b <= CH_LF) begin
      raw_val = 4'(b - CH_LA + 8'd10);
    end else if (b >= CH_UA && b <= CH_UF) begin
      raw_val = 4'(b - CH_UA + 8'd10);
    end else begin
      raw_ok = 1'b0;
    end
  end

  always_comb begin
    unique case (kind)
      K_HEX: begin radix = 5'd16; max_cnt = 4'd2; kind_err = ST_BAD_HEX; end
      K_DEC: begin radix = 5'd10; max_cnt = 4'd3; kind_err = ST_BAD_DEC; end
      K_UNI: begin radix = 5'd16; max_cnt = 4'd8; kind_err = ST_BAD_UNI; end
      K_OCT: begin radix = 5'd8;  max_cnt = 4'd3; kind_err = ST_BAD_OCT; end
      default: begin radix = 5'd16; max_cnt = 4'd2; kind_err = ST_BAD_HEX; end
    endcase
  end

  assign dig_ok  = raw_ok && ({1'b0, raw_val} < radix);
  assign cnt_inc = cnt + 1'b1;

  // acc * radix + digit as shifts and adds
  always_comb begin
    unique case (kind)
      K_DEC:   acc_mul = {acc[28:0], 3'b000} + {acc[30:0], 1'b0};
      K_OCT:   acc_mul = {acc[28:0], 3'b000};
      default: acc_mul = {acc[27:0], 4'h0};
    endcase
    acc_mul = acc_mul + {28'd0, raw_val};
  end

  always_comb begin
    mode_next = mode;
    kind_next = kind;
    cnt_next  = cnt;
    acc_next  = acc;
    err_next  = err;
    fl_req    = 1'b0;
    fl_bad    = 1'b0;
    fl_val    = acc;
    lit_en    = 1'b0;
    lit_byte  = b;

    unique case (mode)
      M_NORMAL: begin
        if (b == CH_BSL && !last) begin
          mode_next = M_ESCAPE;
        end else begin
          lit_en = 1'b1;
        end
      end

      M_ESCAPE: begin
        mode_next = M_NORMAL;
        priority if (b == CH_LA) begin
          lit_en = 1'b1; lit_byte = CTL_BEL;
        end else if (b == CH_LB) begin
          lit_en = 1'b1; lit_byte = CTL_BS;
        end else if (b == CH_LF) begin
          lit_en = 1'b1; lit_byte = CTL_FF;
        end else if (b == CH_LN) begin
          lit_en = 1'b1; lit_byte = CTL_LF;
        end else if (b == CH_LR) begin
          lit_en = 1'b1; lit_byte = CTL_CR;
        end else if (b == CH_LT) begin
          lit_en = 1'b1; lit_byte = CTL_HT;
        end else if (b == CH_LV) begin
          lit_en = 1'b1; lit_byte = CTL_VT;
        end else if (b == CH_LX || b == CH_UX || b == CH_LD || b == CH_UD ||
                     b == CH_LU || b == CH_UU || b == CH_LO || b == CH_UO) begin
          // start a number; an escape letter on the last byte is an error
          acc_next = '0;
          cnt_next = '0;
          if (b == CH_LX || b == CH_UX) begin
            kind_next = K_HEX;
          end else if (b == CH_LD || b == CH_UD) begin
            kind_next = K_DEC;
          end else if (b == CH_LU || b == CH_UU) begin
            kind_next = K_UNI;
          end else begin
            kind_next = K_OCT;
          end
          if (last) begin
            mode_next = M_SKIP;
            if (err == ST_OK) begin
              unique case (kind_next)
                K_HEX:   err_next = ST_BAD_HEX;
                K_DEC:   err_next = ST_BAD_DEC;
                K_UNI:   err_next = ST_BAD_UNI;
                default: err_next = ST_BAD_OCT;
              endcase
            end
          end else begin
            mode_next = M_FIRST;
          end
        end else if (b >= CH_0 && b <= CH_7) begin
          // bare octal digit opens an octal run
          kind_next = K_OCT;
          acc_next  = {29'd0, b[2:0]};
          cnt_next  = 4'd1;
          mode_next = M_DIGITS;
        end else begin
          // backslash, quotes and anything else: the byte itself
          lit_en = 1'b1;
        end
      end

      M_FIRST, M_DIGITS: begin
        if (dig_ok) begin
          acc_next  = acc_mul;
          cnt_next  = cnt_inc;
          mode_next = M_DIGITS;
          if (cnt_inc >= max_cnt) begin
            fl_req = 1'b1;
            fl_val = acc_mul;
          end
        end else if (mode == M_FIRST) begin
          mode_next = M_SKIP;
          if (err == ST_OK) begin
            err_next = kind_err;
          end
        end else begin
          // run ended by a non-digit; the byte is then text or a new escape
          fl_req = 1'b1;
          fl_val = acc;
          if (!bad_cp(kind, acc)) begin
            if (b == CH_BSL && !last) begin
              mode_next = M_ESCAPE;
            end else begin
              lit_en = 1'b1;
            end
          end
        end
      end

      M_SKIP: begin
        mode_next = M_SKIP;
      end

      default: begin
        mode_next = M_SKIP;
      end
    endcase

    // open run at string end is flushed before the terminator
    if (last && mode_next == M_DIGITS && !fl_req) begin
      fl_req = 1'b1;
      fl_val = acc_next;
    end

    if (fl_req) begin
      fl_bad   = bad_cp(kind_next, fl_val);
      acc_next = '0;
      cnt_next = '0;
      if (fl_bad) begin
        mode_next = M_SKIP;
        if (err == ST_OK) begin
          err_next = ST_BAD_CP;
        end
      end else if (mode_next == M_DIGITS) begin
        mode_next = M_NORMAL;
      end
    end
  end

  always_comb begin
    job.fl_en    = fl_req && !fl_bad;
    job.fl_uni   = (kind_next == K_UNI);
    job.fl_val   = (kind_next == K_UNI) ? fl_val[20:0] : {13'd0, fl_val[7:0]};
    job.lit_en   = lit_en;
    job.lit_byte = lit_byte;
    job.term_en  = last;
    job.status   = err_next;
  end

  assign push = accept && (job.fl_en || job.lit_en || job.term_en);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_NORMAL;
      kind <= K_HEX;
      cnt  <= '0;
      acc  <= '0;
      err  <= ST_OK;
    end else if (accept) begin
      if (last) begin
        mode <= M_NORMAL;
        kind <= K_HEX;
        cnt  <= '0;
        acc  <= '0;
        err  <= ST_OK;
      end else begin
        mode <= mode_next;
        kind <= kind_next;
        cnt  <= cnt_next;
        acc  <= acc_next;
        err  <= err_next;
      end
    end
  end

endmodule

// ===== src/sed_back.sv =====
// ----------------------------------------------------------------------------
// sed_back
// Expands queued jobs into beats: UTF-8 or plain number bytes, the literal
// byte, then terminator. One beat per cycle into an output reg unless stalled.
// ----------------------------------------------------------------------------
module sed_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          head_valid,
  input  sed_pkg::job_t head_job,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output sed_pkg::out_t out_data
);
  import sed_pkg::*;

  logic [2:0]  idx;
  logic [2:0]  fl_cnt;
  logic [2:0]  total;
  logic [7:0]  fb [4];
  logic [20:0] c;
  logic        load;
  logic        last_beat;
  out_t        beat;

  assign c = head_job.fl_val;

  // flush bytes and their count
  always_comb begin
    fb[0] = c[7:0];
    fb[1] = 8'h00;
    fb[2] = 8'h00;
    fb[3] = 8'h00;
    fl_cnt = 3'd1;
    if (head_job.fl_uni) begin
      priority if (c < 21'h00080) begin
        fl_cnt = 3'd1;
      end else if (c < 21'h00800) begin
        fl_cnt = 3'd2;
        fb[0]  = {3'b110, c[10:6]};
        fb[1]  = {2'b10, c[5:0]};
      end else if (c < 21'h10000) begin
        fl_cnt = 3'd3;
        fb[0]  = {4'b1110, c[15:12]};
        fb[1]  = {2'b10, c[11:6]};
        fb[2]  = {2'b10, c[5:0]};
      end else begin
        fl_cnt = 3'd4;
        fb[0]  = {5'b11110, c[20:18]};
        fb[1]  = {2'b10, c[17:12]};
        fb[2]  = {2'b10, c[11:6]};
        fb[3]  = {2'b10, c[5:0]};
      end
    end
    if (!head_job.fl_en) begin
      fl_cnt = 3'd0;
    end
  end

  assign total = fl_cnt + {2'b00, head_job.lit_en} + {2'b00, head_job.term_en};

  always_comb begin
    beat.out_byte = 8'h00;
    beat.out_end  = 1'b0;
    beat.status   = ST_OK;
    if (idx < fl_cnt) begin
      beat.out_byte = fb[idx[1:0]];
    end else if (head_job.lit_en && idx == fl_cnt) begin
      beat.out_byte = head_job.lit_byte;
    end else begin
      beat.out_end = 1'b1;
      beat.status  = head_job.status;
    end
  end

  assign load      = head_valid && (!out_valid || out_ready);
  assign last_beat = (idx == total - 3'd1);
  assign pop       = load && last_beat;

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= beat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= last_beat ? 3'd0 : idx + 3'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== src/string_escape_decoder.sv =====
// ----------------------------------------------------------------------------
// string_escape_decoder
// C-style string literal unescaper with hex, decimal, octal and UTF-8 escapes.
// ----------------------------------------------------------------------------
// Takes one raw string byte per beat and returns the decoded bytes, one per
// beat, closing every string (in_last) with a zero byte marked out_end whose
// status carries the first error seen (0 ok, 1 bad hex, 2 bad decimal,
// 3 bad unicode, 4 illegal code point, 5 bad octal); after an error the rest
// of the string produces no data beats. A parser front end takes a byte every
// cycle unless the queue is full and queues at most one job per byte into a
// QDEPTH-entry queue; the back end drains one output beat per cycle while
// out_ready allows. Input throughput is therefore one byte per cycle whenever
// each byte yields at most one output beat and the output does not stall; a
// byte that yields k beats (up to 6: a 4-byte UTF-8 sequence, the byte that
// ended the number, and the terminator) holds the back end until all k are
// out, and input stalls only once the queue fills. in_ready depends only on
// queue fill, and the output register decouples out_ready from the front end.
module string_escape_decoder #(
  parameter int QDEPTH = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  sed_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output sed_pkg::out_t out_data
);
  import sed_pkg::*;

  logic q_full;
  logic push;
  job_t push_job;
  logic pop;
  logic head_valid;
  job_t head_job;

  sed_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .push     (push),
    .job      (push_job)
  );

  sed_fifo #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  sed_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

// ===== src/sed_checker.sv =====
// ----------------------------------------------------------------------------
// sed_checker
// Port-level checks on the decoder's output beats, bound to the top level.
// ----------------------------------------------------------------------------
`include "string_escape_decoder_macros.svh"

module sed_checker (
  input logic          clk,
  input logic          rst,
  input logic          out_valid,
  input logic          out_ready,
  input sed_pkg::out_t out_data
);
  import sed_pkg::*;

  // terminator carries a zero byte
  `SED_ASSERT_IMP(a_term_zero, out_valid && out_data.out_end,
                  out_data.out_byte == 8'h00, "terminator byte not zero")

  // data beats never report an error
  `SED_ASSERT_IMP(a_data_ok, out_valid && !out_data.out_end,
                  out_data.status == ST_OK, "data beat with nonzero status")

  // status stays within the defined codes
  `SED_ASSERT_IMP(a_status_range, out_valid,
                  out_data.status <= ST_BAD_OCT, "undefined status code")

  // stalled beat holds
  `SED_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
                  out_valid && $stable(out_data), "output beat changed while stalled")

endmodule

bind string_escape_decoder sed_checker u_sed_checker (.*);
